// File: rtl/core/frcd_pkg.sv
// ----------------------------------------------------------------------------
// frcd_pkg
// Shared types, status codes and the CRC-8 step for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package frcd_pkg;

  // header layout
  localparam logic [7:0] HDR_BYTES   = 8'd11;
  localparam logic [7:0] CRC_BYTES   = 8'd10;
  localparam logic [7:0] VERSION_ONE = 8'd1;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam int         CFG_W       = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // frame status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_LENGTH  = 3'd4;
  localparam logic [2:0] ST_CRC     = 3'd5;
  localparam logic [2:0] ST_DUP     = 3'd6;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // one queued job: a payload byte, a frame end, or both
  typedef struct packed {
    logic        pay;
    logic        eof;
    logic [7:0]  pbyte;
    logic [2:0]  pre_status;
    logic [15:0] msg_id;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  modc;
    logic [7:0]  mtype;
    logic [7:0]  opc;
    logic [7:0]  flags;
    logic [7:0]  plen;
  } job_t;

  // one result beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [2:0]  status;
    logic [15:0] msg_id;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  modc;
    logic [7:0]  mtype;
    logic [7:0]  opc;
    logic [7:0]  flags;
    logic [7:0]  plen;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_STAT
  } back_state_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/frcd_ram.sv
// ----------------------------------------------------------------------------
// frcd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/frcd_front.sv
// ----------------------------------------------------------------------------
// frcd_front
// Byte intake: header capture, CRC-8, length tracking and the early checks.
// Emits one job per beat that yields a payload byte or ends a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module frcd_front #(
  parameter int MAX_FRAME_BYTES = 200
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_eof,
  output logic                   push,
  output frcd_pkg::job_t         push_job,
  input  wire logic              q_full
);

  localparam logic [7:0] MAX_PLEN = 8'(MAX_FRAME_BYTES - 11);

  logic [7:0] cnt_r, cnt_nxt;
  logic       over_r, over_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] hdr_r   [11];
  logic [7:0] hdr_nxt [11];

  logic       accept;
  logic       in_hdr;
  logic [7:0] cnt_inc;
  logic       over_inc;
  logic [7:0] crc_upd;
  logic [2:0] pre;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign in_hdr   = cnt_r < frcd_pkg::HDR_BYTES;

  // header with the current beat written in
  always_comb begin
    for (int k = 0; k < 11; k++) begin
      hdr_nxt[k] = (in_hdr && cnt_r == 8'(k)) ? in_byte : hdr_r[k];
    end
  end

  // count, overflow and CRC as seen after this beat
  always_comb begin
    cnt_inc  = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
    over_inc = over_r || (cnt_r == 8'hFF);
    crc_upd  = (cnt_r < frcd_pkg::CRC_BYTES) ? frcd_pkg::crc8_byte(crc_r, in_byte) : crc_r;
  end

  // early checks in priority order
  always_comb begin
    if (cnt_inc < frcd_pkg::HDR_BYTES) begin
      pre = frcd_pkg::ST_SHORT;
    end else if (hdr_nxt[0] != frcd_pkg::VERSION_ONE) begin
      pre = frcd_pkg::ST_VERSION;
    end else if (hdr_nxt[9] > MAX_PLEN) begin
      pre = frcd_pkg::ST_LONG;
    end else if (over_inc ||
                 {1'b0, cnt_inc} != ({1'b0, frcd_pkg::HDR_BYTES} + {1'b0, hdr_nxt[9]})) begin
      pre = frcd_pkg::ST_LENGTH;
    end else if (crc_upd != hdr_nxt[10]) begin
      pre = frcd_pkg::ST_CRC;
    end else begin
      pre = frcd_pkg::ST_OK;
    end
  end

  // build the job
  always_comb begin
    push_job.pay        = !in_hdr;
    push_job.eof        = in_eof;
    push_job.pbyte      = in_byte;
    push_job.pre_status = pre;
    push_job.msg_id     = {hdr_nxt[2], hdr_nxt[1]};
    push_job.src        = hdr_nxt[3];
    push_job.dst        = hdr_nxt[4];
    push_job.modc       = hdr_nxt[5];
    push_job.mtype      = hdr_nxt[6];
    push_job.opc        = hdr_nxt[7];
    push_job.flags      = hdr_nxt[8];
    push_job.plen       = hdr_nxt[9];
    push                = accept && (!in_hdr || in_eof);
  end

  // frame tracking, restart at frame end
  always_comb begin
    cnt_nxt  = cnt_r;
    over_nxt = over_r;
    crc_nxt  = crc_r;
    if (accept) begin
      if (in_eof) begin
        cnt_nxt  = 8'd0;
        over_nxt = 1'b0;
        crc_nxt  = 8'd0;
      end else begin
        cnt_nxt  = cnt_inc;
        over_nxt = over_inc;
        crc_nxt  = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 8'd0;
      over_r <= 1'b0;
      crc_r  <= 8'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      over_r <= over_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // header bytes hold until the next frame overwrites them
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 11; k++) begin
        hdr_r[k] <= hdr_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/frcd_queue.sv
// ----------------------------------------------------------------------------
// frcd_queue
// Short job queue between intake and the dedup back end.
// ----------------------------------------------------------------------------
`default_nettype none

module frcd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire frcd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output frcd_pkg::job_t      head,
  output logic                q_valid
);

  frcd_pkg::job_t                 mem_r [frcd_pkg::QDEPTH];
  logic [frcd_pkg::QAW-1:0]       wr_r, wr_nxt;
  logic [frcd_pkg::QAW-1:0]       rd_r, rd_nxt;
  logic [frcd_pkg::QAW:0]         cnt_r, cnt_nxt;

  assign full    = cnt_r == (frcd_pkg::QAW + 1)'(frcd_pkg::QDEPTH);
  assign q_valid = cnt_r != '0;
  assign head    = mem_r[rd_r];

  // advance pointers and count
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/frcd_back.sv
// ----------------------------------------------------------------------------
// frcd_back
// Result side: payload forwarding, duplicate search over the key ring,
// key recording and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frcd_back #(
  parameter int DEDUP_DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wen,
  input  wire logic [frcd_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire frcd_pkg::job_t              head,
  input  wire logic                        q_valid,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output frcd_pkg::res_t                   out_res
);

  localparam int AW     = (DEDUP_DEPTH > 1) ? $clog2(DEDUP_DEPTH) : 1;
  localparam int FILL_W = $clog2(DEDUP_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int CW     = (FILL_W > frcd_pkg::CFG_W) ? FILL_W : frcd_pkg::CFG_W;

  frcd_pkg::back_state_t state_r, state_nxt;
  frcd_pkg::job_t        job_r, job_nxt;
  frcd_pkg::res_t        out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [FILL_W-1:0]     scnt_r, scnt_nxt;
  logic                  dup_r, dup_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]         oldest_r, oldest_nxt;
  logic [frcd_pkg::CFG_W-1:0] cfg_r;

  logic          out_free;
  logic [23:0]   key;
  logic [23:0]   rdata;
  logic          hit;
  logic          scan_done;
  logic [2:0]    fin_status;
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] lim;
  logic          evict;
  logic [AW-1:0]     o1;
  logic [FILL_W-1:0] f1;
  logic [SUM_W-1:0]  wsum;
  logic [SUM_W-1:0]  wpos;

  assign out_free  = !out_valid_r || out_ready;
  assign key       = {job_r.src, job_r.msg_id};
  assign hit       = rdata == key;
  assign scan_done = (scnt_r + 1'b1) == fill_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, p} + 1'b1;
    return (s == (AW + 1)'(DEDUP_DEPTH)) ? '0 : s[AW-1:0];
  endfunction

  // key ring storage
  frcd_ram #(
    .WIDTH (24),
    .DEPTH (DEDUP_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (key),
    .raddr (ptr_r),
    .rdata (rdata)
  );

  // effective ring size: zero acts as one, capped at the depth
  always_comb begin
    if (cfg_r == '0) begin
      lim = CW'(1);
    end else if (CW'(cfg_r) > CW'(DEDUP_DEPTH)) begin
      lim = CW'(DEDUP_DEPTH);
    end else begin
      lim = CW'(cfg_r);
    end
  end

  // slot for a new key, dropping the oldest one when full
  always_comb begin
    evict = (CW'(fill_r) >= lim) && (fill_r != '0);
    o1    = evict ? ring_inc(oldest_r) : oldest_r;
    f1    = evict ? fill_r - 1'b1 : fill_r;
    wsum  = SUM_W'(o1) + SUM_W'(f1);
    wpos  = (wsum >= SUM_W'(DEDUP_DEPTH)) ? wsum - SUM_W'(DEDUP_DEPTH) : wsum;
    waddr = wpos[AW-1:0];
  end

  assign fin_status = (job_r.pre_status != frcd_pkg::ST_OK) ? job_r.pre_status :
                      (dup_r ? frcd_pkg::ST_DUP : frcd_pkg::ST_OK);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frcd_pkg::BK_IDLE: begin
        if (q_valid && out_free && head.eof) begin
          if (head.pre_status == frcd_pkg::ST_OK && fill_r != '0) begin
            state_nxt = frcd_pkg::BK_READ;
          end else begin
            state_nxt = frcd_pkg::BK_STAT;
          end
        end
      end
      frcd_pkg::BK_READ: begin
        state_nxt = frcd_pkg::BK_CMP;
      end
      frcd_pkg::BK_CMP: begin
        if (hit || scan_done) begin
          state_nxt = frcd_pkg::BK_STAT;
        end else begin
          state_nxt = frcd_pkg::BK_READ;
        end
      end
      frcd_pkg::BK_STAT: begin
        if (out_free) begin
          state_nxt = frcd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = frcd_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    pop           = 1'b0;
    job_nxt       = job_r;
    ptr_nxt       = ptr_r;
    scnt_nxt      = scnt_r;
    dup_nxt       = dup_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    ram_we        = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      frcd_pkg::BK_IDLE: begin
        if (q_valid && out_free) begin
          pop      = 1'b1;
          job_nxt  = head;
          ptr_nxt  = oldest_r;
          scnt_nxt = '0;
          dup_nxt  = 1'b0;
          if (head.pay) begin
            out_nxt       = '0;
            out_nxt.kind  = frcd_pkg::KIND_PAYLOAD;
            out_nxt.pbyte = head.pbyte;
            out_nxt.last  = !head.eof;
            out_valid_nxt = 1'b1;
          end
        end
      end
      frcd_pkg::BK_READ: begin
      end
      frcd_pkg::BK_CMP: begin
        if (hit) begin
          dup_nxt = 1'b1;
        end else if (!scan_done) begin
          ptr_nxt  = ring_inc(ptr_r);
          scnt_nxt = scnt_r + 1'b1;
        end
      end
      frcd_pkg::BK_STAT: begin
        if (out_free) begin
          out_nxt        = '0;
          out_nxt.kind   = frcd_pkg::KIND_STATUS;
          out_nxt.status = fin_status;
          out_nxt.last   = 1'b1;
          if (fin_status != frcd_pkg::ST_SHORT) begin
            out_nxt.msg_id = job_r.msg_id;
            out_nxt.src    = job_r.src;
            out_nxt.dst    = job_r.dst;
            out_nxt.modc   = job_r.modc;
            out_nxt.mtype  = job_r.mtype;
            out_nxt.opc    = job_r.opc;
            out_nxt.flags  = job_r.flags;
            out_nxt.plen   = job_r.plen;
          end
          out_valid_nxt = 1'b1;
          // record a fresh key
          if (fin_status == frcd_pkg::ST_OK) begin
            ram_we     = 1'b1;
            oldest_nxt = o1;
            fill_nxt   = f1 + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frcd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      oldest_r    <= '0;
      cfg_r       <= frcd_pkg::CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      if (cfg_wen) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    ptr_r  <= ptr_nxt;
    scnt_r <= scnt_nxt;
    dup_r  <= dup_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/frame_receiver_crc8_dedup_top.sv
// Path: a payload byte passes through the job queue and the output register to out_tvalid.
// Throughput: one byte per cycle through the header and payload while the queue is not full;
// a frame end reads and compares each stored key in turn; four queued jobs stall input.
// Reset: rst_n synchronous, active low; clears frame counters, empties the key
// ring (fill count to zero, no clearing pass) and sets dedup_entries to 32.
// ----------------------------------------------------------------------------
// frame_receiver_crc8_dedup_top
// Frame receiver with header CRC-8 check and duplicate key filter.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receiver_crc8_dedup_top #(
  parameter int DEDUP_DEPTH     = 32,
  parameter int MAX_FRAME_BYTES = 200
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [5:0]  cfg_wdata,   // dedup_entries
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // rx_byte [7:0]
  input  wire logic        in_tlast,    // end_of_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // payload_byte [7:0], status [10:8], message_id [26:11], source_id [34:27],
  // dest_id [42:35], module_code [50:43], message_type [58:51], op_code [66:59],
  // flag_bits [74:67], payload_length [82:75], zero [87:83]
  output logic [87:0]      out_tdata,
  output logic             out_tuser,   // kind
  output logic             out_tlast    // last_result
);

  logic           push;
  frcd_pkg::job_t push_job;
  logic           q_full;
  logic           pop;
  frcd_pkg::job_t head;
  logic           q_valid;
  frcd_pkg::res_t res;

  frcd_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_eof   (in_tlast),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  frcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .q_valid  (q_valid)
  );

  frcd_back #(
    .DEDUP_DEPTH (DEDUP_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result beat
  assign out_tdata = {5'b0, res.plen, res.flags, res.opc, res.mtype, res.modc,
                      res.dst, res.src, res.msg_id, res.status, res.pbyte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

// File: rtl/core/frcd_checker.sv
// ----------------------------------------------------------------------------
// frcd_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module frcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // payload beats carry a zero status and no header fields
  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[87:8] == '0)
    else $error("payload beat carries status or header bits");

  // a status beat always closes the input beat's results
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("status beat without last flag");

  // short frames report no header fields, codes stay in range
  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[10:8] == frcd_pkg::ST_SHORT |->
    out_tdata[87:11] == '0)
    else $error("short frame status carries header fields");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[10:8] <= frcd_pkg::ST_DUP &&
    out_tdata[7:0] == 8'd0)
    else $error("status beat with bad code or payload byte");

endmodule

bind frame_receiver_crc8_dedup_top frcd_checker u_frcd_checker (.*);

`default_nettype wire
